### rtl/core/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg
// Shared constants and types for the edit distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

  localparam int MAX_LEN = 64;
  localparam int LEN_W   = $clog2(MAX_LEN + 2);

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_PROCESS = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [6:0] distance;
    logic       error;
  } out_word_t;

  typedef struct packed {
    logic             tok;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] diag;
  } link_t;

  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [LEN_W-1:0] tlen;
    logic [7:0]       wr_sym;
    logic [7:0]       src_sym;
  } cell_ctl_t;

endpackage

### rtl/core/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance over a chain of per-column DP cells.
// Clear, append and query complete without raising busy; a query result
// strobes on the cycle after acceptance. A process word sweeps the row token
// down all MAX_LEN cells, one cell per cycle; busy holds until the token
// leaves the last cell, blocking new words. Receiver cannot stall results.
// Synchronous reset loads the empty-word state (DP row 0..MAX_LEN).
// ----------------------------------------------------------------------------
module edit_distance_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ede_pkg::in_word_t   in_word,
  output logic                out_valid,
  output ede_pkg::out_word_t  out_word
);
  import ede_pkg::*;

  cell_ctl_t ctl;
  link_t     chain [0:MAX_LEN];

  ede_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .ctl       (ctl),
    .head      (chain[0]),
    .tail      (chain[MAX_LEN])
  );

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    ede_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (LEN_W'(j)),
      .ctl      (ctl),
      .link_in  (chain[j-1]),
      .link_out (chain[j])
    );
  end

  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_word.command == CMD_QUERY)))
    else $error("result strobe without query");

  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_LEN].tok |-> busy)
    else $error("row token left chain while idle");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.distance <= 7'(MAX_LEN)))
    else $error("distance above saturation");

  a_busy_on_process: assert property (@(posedge clk) disable iff (!rst_n)
    chain[0].tok |-> busy)
    else $error("row sweep started without busy");

endmodule

### rtl/core/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell
// One column of the DP row: holds a target byte and its DP cell, updates the
// cell when the row token passes and hands the new value to its neighbor.
// ----------------------------------------------------------------------------
module ede_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ede_pkg::LEN_W-1:0]      cell_idx,
  input  ede_pkg::cell_ctl_t             ctl,
  input  ede_pkg::link_t                 link_in,
  output ede_pkg::link_t                 link_out
);
  import ede_pkg::*;

  logic [7:0]       char_r;
  logic [LEN_W-1:0] dp_r;
  logic             tok_r;
  logic [LEN_W-1:0] left_r;
  logic [LEN_W-1:0] diag_r;

  logic             active;
  logic [LEN_W-1:0] sub_c;
  logic [LEN_W-1:0] up_c;
  logic [LEN_W-1:0] lf_c;
  logic [LEN_W-1:0] m1;
  logic [LEN_W-1:0] m2;
  logic [LEN_W-1:0] cell_nxt;

  assign active = (cell_idx <= ctl.tlen);

  always_comb begin
    sub_c = link_in.diag + ((char_r != ctl.src_sym) ? LEN_W'(1) : LEN_W'(0));
    up_c  = dp_r + LEN_W'(1);
    lf_c  = link_in.left + LEN_W'(1);
    m1    = (sub_c < up_c) ? sub_c : up_c;
    m2    = (m1 < lf_c) ? m1 : lf_c;
    cell_nxt = (m2 > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : m2;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (ctl.tlen == cell_idx - LEN_W'(1))) begin
      char_r <= ctl.wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r  <= cell_idx;
      tok_r <= 1'b0;
    end else begin
      tok_r <= link_in.tok;
      if (ctl.clear) begin
        dp_r <= cell_idx;
      end else if (link_in.tok && active) begin
        dp_r <= cell_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.tok) begin
      left_r <= active ? cell_nxt : link_in.left;
      diag_r <= dp_r;
    end
  end

  assign link_out.tok  = tok_r;
  assign link_out.left = left_r;
  assign link_out.diag = diag_r;

endmodule

### rtl/core/ede_ctrl.sv
// ----------------------------------------------------------------------------
// ede_ctrl
// Command decode, word lengths, error flag, column-zero cell and result word.
// ----------------------------------------------------------------------------
module ede_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ede_pkg::in_word_t   in_word,
  output logic                out_valid,
  output ede_pkg::out_word_t  out_word,
  output ede_pkg::cell_ctl_t  ctl,
  output ede_pkg::link_t      head,
  input  ede_pkg::link_t      tail
);
  import ede_pkg::*;

  logic             busy_r;
  logic [LEN_W-1:0] slen_r;
  logic [LEN_W-1:0] tlen_r;
  logic             err_r;
  logic [LEN_W-1:0] dist_r;
  logic [7:0]       sym_r;
  logic             head_tok_r;
  logic [LEN_W-1:0] head_left_r;
  logic [LEN_W-1:0] head_diag_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic acc;
  logic app_ok;

  assign acc    = start && !busy_r;
  assign app_ok = (slen_r == '0) && (tlen_r != LEN_W'(MAX_LEN));

  always_comb begin
    ctl.clear   = acc && (in_word.command == CMD_CLEAR);
    ctl.wr_en   = acc && (in_word.command == CMD_APPEND) && app_ok;
    ctl.tlen    = tlen_r;
    ctl.wr_sym  = in_word.symbol;
    ctl.src_sym = sym_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slen_r      <= '0;
      tlen_r      <= '0;
      err_r       <= 1'b0;
      dist_r      <= '0;
      head_tok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_tok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      if (busy_r && tail.tok) begin
        busy_r <= 1'b0;
        dist_r <= tail.left;
      end
      if (acc) begin
        unique case (in_word.command)
          CMD_CLEAR: begin
            slen_r <= '0;
            tlen_r <= '0;
            err_r  <= 1'b0;
            dist_r <= '0;
          end
          CMD_APPEND: begin
            if (app_ok) begin
              tlen_r <= tlen_r + LEN_W'(1);
              dist_r <= tlen_r + LEN_W'(1);
            end else begin
              err_r <= 1'b1;
            end
          end
          CMD_PROCESS: begin
            if (slen_r == LEN_W'(MAX_LEN)) begin
              err_r <= 1'b1;
            end else begin
              slen_r     <= slen_r + LEN_W'(1);
              head_tok_r <= 1'b1;
              busy_r     <= 1'b1;
            end
          end
          CMD_QUERY: begin
            out_valid_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (in_word.command == CMD_PROCESS)) begin
      sym_r       <= in_word.symbol;
      head_left_r <= slen_r + LEN_W'(1);
      head_diag_r <= slen_r;
    end
    if (acc && (in_word.command == CMD_QUERY)) begin
      out_word_r.distance <= dist_r[6:0];
      out_word_r.error    <= err_r;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign head.tok  = head_tok_r;
  assign head.left = head_left_r;
  assign head.diag = head_diag_r;

endmodule

### verif/ede_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_checker
// Watches the command and result channels of the edit distance engine. Keeps
// its own target word, DP row, word lengths and sticky error, predicts the
// distance word for every accepted query and compares each result strobe,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ede_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ede_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  ede_pkg::out_word_t out_word,
  output int                 pending,
  output int                 mismatches
);
  import ede_pkg::*;

  logic [7:0] target_sym [MAX_LEN];
  logic [6:0] row_cost   [MAX_LEN + 1];
  int         target_len;
  int         source_len;
  logic       sticky_err;
  out_word_t  dist_q[$];
  out_word_t  oldest;
  int         mismatch_count = 0;

  assign mismatches = mismatch_count;

  function automatic void clear_words();
    int j;
    for (j = 0; j <= MAX_LEN; j++) row_cost[j] = 7'(j);
    target_len = 0;
    source_len = 0;
    sticky_err = 1'b0;
  endfunction

  function automatic void advance_row(logic [7:0] ch);
    int j;
    int diag;
    int up;
    int best;
    if (source_len >= MAX_LEN) begin
      sticky_err = 1'b1;
      return;
    end
    source_len++;
    diag = int'(row_cost[0]);
    row_cost[0] = 7'(source_len);
    for (j = 1; j <= target_len; j++) begin
      up = int'(row_cost[j]);
      best = diag + ((target_sym[j - 1] != ch) ? 1 : 0);
      if (up + 1 < best) best = up + 1;
      if (int'(row_cost[j - 1]) + 1 < best) best = int'(row_cost[j - 1]) + 1;
      if (best > MAX_LEN) best = MAX_LEN;
      diag = up;
      row_cost[j] = 7'(best);
    end
  endfunction

  function automatic void apply_word(in_word_t w);
    out_word_t want;
    case (w.command)
      CMD_CLEAR: clear_words();
      CMD_APPEND: begin
        if (source_len != 0 || target_len >= MAX_LEN) begin
          sticky_err = 1'b1;
        end else begin
          target_sym[target_len] = w.symbol;
          target_len++;
        end
      end
      CMD_PROCESS: advance_row(w.symbol);
      CMD_QUERY: begin
        want.distance = row_cost[target_len];
        want.error    = sticky_err;
        dist_q.push_back(want);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_words();
      dist_q.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (dist_q.size() == 0) begin
          report_mismatch("unrequested distance word", 32'(out_word), 0);
        end else begin
          oldest = dist_q.pop_front();
          if (out_word.distance !== oldest.distance)
            report_mismatch("distance", 32'(out_word.distance), 32'(oldest.distance));
          if (out_word.error !== oldest.error)
            report_mismatch("error", 32'(out_word.error), 32'(oldest.error));
        end
      end
      if (start && !busy) apply_word(in_word);
    end
    pending <= dist_q.size();
  end

endmodule

### verif/tb_edit_distance_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edit_distance_engine
// Drives the edit distance engine with a short directed run (empty words,
// extreme bytes, misordered append, clear of the sticky error) and then with
// random word pairs: mostly clear, target, source and query sequences built
// from narrow or full alphabets, plus length overflow, noise and sequences
// without a clear. A checker beside the engine predicts every distance word.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine;
  import ede_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int WORD_TARGET = 1650;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;
  int        pending;
  int        mismatches;
  int        sent = 0;
  int        idle_cycles = 0;
  int        no_gap_run = 0;
  int        alpha_base;
  int        alpha_size;
  logic [7:0] target_word [MAX_LEN];

  edit_distance_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  ede_checker dist_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("edit_distance_engine regression: fail");
        $finish;
      end
    end
  end

  function automatic void new_alphabet();
    int r;
    r = $urandom_range(0, 9);
    alpha_base = $urandom_range(0, 255);
    if (r == 0) alpha_size = 1;
    else if (r < 4) alpha_size = 2;
    else if (r < 7) alpha_size = 4;
    else if (r < 9) alpha_size = 8;
    else alpha_size = 256;
  endfunction

  function automatic logic [7:0] pick_symbol();
    if (alpha_size >= 256) return 8'($urandom);
    return 8'(alpha_base + $urandom_range(0, alpha_size - 1));
  endfunction

  function automatic logic [7:0] source_symbol(int pos, int tlen);
    if (pos < tlen && $urandom_range(0, 9) < 6) return target_word[pos];
    return pick_symbol();
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 92) return $urandom_range(7, 20);
    return $urandom_range(MAX_LEN - 8, MAX_LEN);
  endfunction

  task automatic pause_sender();
    int r;
    int n;
    if (no_gap_run > 0) begin
      no_gap_run--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_run = $urandom_range(20, 80);
      return;
    end
    if (r < 55) return;
    n = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 60);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] sym);
    start   <= 1'b1;
    in_word <= '{command: cmd, symbol: sym};
    do @(posedge clk); while (busy);
    sent++;
    pause_sender();
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    int tlen;
    int slen;
    int kind;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_word(CMD_QUERY, 8'hFF);
    send_word(CMD_CLEAR, 8'hA5);
    send_word(CMD_APPEND, 8'h00);
    send_word(CMD_APPEND, 8'hFF);
    send_word(CMD_APPEND, 8'h5A);
    send_word(CMD_QUERY, 8'h00);
    send_word(CMD_PROCESS, 8'hFF);
    send_word(CMD_PROCESS, 8'h00);
    send_word(CMD_QUERY, 8'h3C);
    send_word(CMD_APPEND, 8'h11);
    send_word(CMD_QUERY, 8'hC3);
    send_word(CMD_PROCESS, 8'h5A);
    send_word(CMD_QUERY, 8'h00);
    send_word(CMD_CLEAR, 8'h00);
    send_word(CMD_QUERY, 8'h00);
    send_word(CMD_PROCESS, 8'h80);
    send_word(CMD_PROCESS, 8'h7F);
    send_word(CMD_QUERY, 8'h00);
    send_word(CMD_CLEAR, 8'hFF);
    send_word(CMD_APPEND, 8'h01);
    send_word(CMD_PROCESS, 8'h01);
    send_word(CMD_QUERY, 8'h00);
    wait_for_results();

    while (sent < WORD_TARGET) begin
      kind = $urandom_range(0, 99);
      new_alphabet();
      if (kind < 70) begin
        send_word(CMD_CLEAR, 8'($urandom));
        tlen = pick_length();
        for (i = 0; i < tlen; i++) begin
          target_word[i] = pick_symbol();
          send_word(CMD_APPEND, target_word[i]);
        end
        if ($urandom_range(0, 4) == 0) send_word(CMD_QUERY, 8'($urandom));
        slen = pick_length();
        for (i = 0; i < slen; i++) begin
          send_word(CMD_PROCESS, source_symbol(i, tlen));
          if ($urandom_range(0, 6) == 0) send_word(CMD_QUERY, 8'($urandom));
        end
        send_word(CMD_QUERY, 8'($urandom));
      end else if (kind < 77) begin
        send_word(CMD_CLEAR, 8'($urandom));
        tlen = MAX_LEN + $urandom_range(1, 3);
        for (i = 0; i < tlen; i++) begin
          if (i < MAX_LEN) target_word[i] = pick_symbol();
          send_word(CMD_APPEND, (i < MAX_LEN) ? target_word[i] : pick_symbol());
        end
        slen = $urandom_range(0, 4);
        for (i = 0; i < slen; i++) send_word(CMD_PROCESS, source_symbol(i, MAX_LEN));
        send_word(CMD_QUERY, 8'($urandom));
      end else if (kind < 79) begin
        send_word(CMD_CLEAR, 8'($urandom));
        tlen = $urandom_range(0, 4);
        for (i = 0; i < tlen; i++) begin
          target_word[i] = pick_symbol();
          send_word(CMD_APPEND, target_word[i]);
        end
        slen = MAX_LEN + $urandom_range(1, 2);
        for (i = 0; i < slen; i++) send_word(CMD_PROCESS, source_symbol(i, tlen));
        send_word(CMD_QUERY, 8'($urandom));
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 8)) send_word(2'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(0, 3)) send_word(CMD_APPEND, pick_symbol());
        repeat ($urandom_range(1, 3)) send_word(CMD_PROCESS, pick_symbol());
        send_word(CMD_QUERY, 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (MAX_LEN + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("edit_distance_engine regression: pass");
    end else begin
      $display("edit_distance_engine regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ede_pkg.sv
rtl/core/ede_cell.sv
rtl/core/ede_ctrl.sv
rtl/core/edit_distance_engine.sv
verif/ede_checker.sv
verif/tb_edit_distance_engine.sv
